// File: sv/dc_pkg.sv
// Shared types and constants for the density clustering block.
// Holds the command, register index and sequencer state codes.
// No dependencies.
`default_nettype none

package dc_pkg;

    localparam int EPS_W      = 36;
    localparam int MINPTS_W   = 11;
    localparam int PCOUNT_W   = 11;
    localparam int DIMS_W     = 3;
    localparam int CFG_DATA_W = 36;
    localparam int CFG_IDX_W  = 2;
    localparam int CMD_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EPS         = 2'd0,
        CFG_MIN_PTS     = 2'd1,
        CFG_POINT_COUNT = 2'd2,
        CFG_DIMS        = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SEED,
        ST_SEED_CHK,
        ST_SCAN,
        ST_CORE,
        ST_POP,
        ST_POP_Q,
        ST_POP_CHK,
        ST_NOISE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic visited;
        logic queued;
    } t_flags;

endpackage

`default_nettype wire

// File: sv/dc_point_mem.sv
// Point memory: coordinates per point plus the breadth-first queue field.
// Both fields share one read address; each has its own write enable.
// Depends on nothing.
`default_nettype none

module dc_point_mem #(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_DIM     = 4,
    parameter int COORD_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(MAX_POINTS)-1:0]    i_wa,
    input  logic [MAX_DIM*COORD_WIDTH-1:0]   i_wd,
    input  logic                             i_qwe,
    input  logic [$clog2(MAX_POINTS)-1:0]    i_qwa,
    input  logic [$clog2(MAX_POINTS)-1:0]    i_qwd,
    input  logic [$clog2(MAX_POINTS)-1:0]    i_ra,
    output logic [MAX_DIM*COORD_WIDTH-1:0]   o_rd,
    output logic [$clog2(MAX_POINTS)-1:0]    o_rq
);

    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CFW = MAX_DIM * COORD_WIDTH;

    logic [CFW-1:0] r_coord_mem [MAX_POINTS];
    logic [IW-1:0]  r_queue_mem [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_coord_mem[i_wa] <= i_wd;
        end
        o_rd <= r_coord_mem[i_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_qwe) begin
            r_queue_mem[i_qwa] <= i_qwd;
        end
        o_rq <= r_queue_mem[i_ra];
    end

endmodule

`default_nettype wire

// File: sv/dc_flag_mem.sv
// Per-point flag memory: visited bit, queued bit and cluster label.
// One write port, one registered read port.
// Depends on nothing.
`default_nettype none

module dc_flag_mem #(
    parameter int MAX_POINTS = 1024,
    parameter int WORD_W     = 13
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wa,
    input  logic [WORD_W-1:0]             i_wd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_ra,
    output logic [WORD_W-1:0]             o_rd
);

    logic [WORD_W-1:0] r_mem [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end

endmodule

`default_nettype wire

// File: sv/dc_dist.sv
// Two-stage neighbour test: per-lane squared differences, then sum and compare.
// Carries a tag alongside each pair. Uses dc_pkg for the radius width.
`default_nettype none

module dc_dist #(
    parameter int MAX_DIM     = 4,
    parameter int COORD_WIDTH = 16,
    parameter int TAG_W       = 23
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [TAG_W-1:0]               i_tag,
    input  logic [MAX_DIM*COORD_WIDTH-1:0] i_a,
    input  logic [MAX_DIM*COORD_WIDTH-1:0] i_b,
    input  logic [MAX_DIM-1:0]             i_lane_en,
    input  logic [dc_pkg::EPS_W-1:0]       i_eps,
    output logic                           o_valid,
    output logic                           o_near,
    output logic [TAG_W-1:0]               o_tag,
    output logic                           o_busy
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int SQW  = 2 * DW;
    localparam int SUMW = SQW + $clog2(MAX_DIM) + 1;
    localparam int CMPW = (SUMW > dc_pkg::EPS_W) ? SUMW : dc_pkg::EPS_W;

    logic [SQW-1:0]   r_sq [MAX_DIM];
    logic [SQW-1:0]   sq   [MAX_DIM];
    logic             r_v1;
    logic [TAG_W-1:0] r_tag1;
    logic [SUMW-1:0]  sum;

    genvar gd;
    generate
        for (gd = 0; gd < MAX_DIM; gd++) begin : g_lane
            logic signed [DW-1:0] diff;
            logic [DW-1:0]        mag;
            assign diff = DW'($signed(i_a[gd*COORD_WIDTH +: COORD_WIDTH]))
                        - DW'($signed(i_b[gd*COORD_WIDTH +: COORD_WIDTH]));
            assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
            assign sq[gd] = SQW'(mag) * SQW'(mag);
        end
    endgenerate

    always_comb begin
        sum = '0;
        for (int d = 0; d < MAX_DIM; d++) begin
            sum = sum + SUMW'(r_sq[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < MAX_DIM; d++) begin
            r_sq[d] <= i_lane_en[d] ? sq[d] : '0;
        end
        r_tag1 <= i_tag;
        o_tag  <= r_tag1;
        o_near <= (CMPW'(sum) <= CMPW'(i_eps));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    assign o_busy = r_v1 | o_valid;

endmodule

`default_nettype wire

// File: sv/density_clustering.sv
// Density clustering (DBSCAN) over stored points: sequencer and registers.
// Depends on dc_pkg, dc_point_mem, dc_flag_mem and dc_dist.
//
// Usage: the user must have the configuration channel write eps_squared,
// min_pts, point_count and dims by index only while the block is idle; the
// block leaves this to the user and the channel is always ready. Each input
// transfer carries one command and gives exactly one output transfer. A load
// stores one point and answers in the cycle after acceptance. A label read
// answers from ST_READ, once the registered flag memory read is available.
// A run clears all MAX_POINTS flag entries, takes unvisited points in index
// order as seeds and grows each cluster breadth first through the queue;
// every visited point costs one scan over the first point_count points, and
// every core point a second scan, each through the memory read and the
// two-stage distance unit; noise labels among those points are counted last.
// One command is in flight at a time; the next is accepted once the output
// register is free or being drained. A stalled receiver holds the result.
// After reset all MAX_POINTS flag entries are cleared, during which no
// command is accepted; configuration writes are taken throughout.
`default_nettype none

module density_clustering #(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_DIM     = 4,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dc_pkg::CMD_W-1:0]            i_command,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_point_index,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_0,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_1,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_2,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_3,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [$clog2(MAX_POINTS):0]  o_label,
    output logic [$clog2(MAX_POINTS):0]         o_cluster_total,
    output logic [$clog2(MAX_POINTS):0]         o_noise_total,
    output logic                                o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int LW   = IW + 1;
    localparam int FW   = LW + 2;
    localparam int CFW  = MAX_DIM * COORD_WIDTH;
    localparam int TW   = IW + FW;
    localparam int CNTW = (LW > dc_pkg::MINPTS_W) ? LW : dc_pkg::MINPTS_W;
    localparam logic [IW:0]   MAXP  = (IW+1)'(MAX_POINTS);
    localparam logic [IW:0]   LASTP = (IW+1)'(MAX_POINTS - 1);
    localparam logic [LW-1:0] NOISE = {LW{1'b1}};

    dc_pkg::t_state r_state, n_state;

    logic [dc_pkg::EPS_W-1:0]    r_eps;
    logic [dc_pkg::MINPTS_W-1:0] r_min_pts;
    logic [dc_pkg::PCOUNT_W-1:0] r_pcount;
    logic [dc_pkg::DIMS_W-1:0]   r_dims;

    logic [IW:0]     r_i, r_j, r_k, r_head, r_tail, r_cnt, r_next, r_ncnt;
    logic [IW:0]     r_clusters, r_noise;
    logic [IW-1:0]   r_cur, r_s1_j;
    logic [CFW-1:0]  r_cur_c;
    logic            r_cur_q, r_seed, r_enq, r_s1_v, r_nv, r_rd_bad;
    logic            r_ov;
    logic [LW-1:0]   r_o_label;
    logic [IW:0]     r_o_clusters, r_o_noise;
    logic            r_o_status;

    logic [IW:0]          eff_n;
    logic [31:0]          pc_sat;
    logic [MAX_DIM-1:0]   lane_en;
    logic [CFW-1:0]       load_c;
    logic [COORD_WIDTH-1:0] coord_in [4];
    logic                 in_acc, cfg_acc, is_core;
    logic                 issue, issue_n, cnt_inc;

    logic                 pt_we, q_we;
    logic [IW-1:0]        pt_ra;
    logic [CFW-1:0]       pt_rd;
    logic [IW-1:0]        pt_q;
    logic                 fl_we;
    logic [IW-1:0]        fl_wa, fl_ra;
    logic [FW-1:0]        fl_wd, fl_rd;
    dc_pkg::t_flags       fl_rf;
    logic [LW-1:0]        fl_label;

    logic                 near_v, near, dist_busy;
    logic [TW-1:0]        near_tag;
    logic [IW-1:0]        tag_j;
    dc_pkg::t_flags       tag_f;
    logic [LW-1:0]        tag_label;
    logic                 ld_plain, ld_read, ld_done;

    assign fl_rf     = dc_pkg::t_flags'(fl_rd[FW-1:LW]);
    assign fl_label  = fl_rd[LW-1:0];
    assign tag_j     = near_tag[TW-1:FW];
    assign tag_f     = dc_pkg::t_flags'(near_tag[FW-1:LW]);
    assign tag_label = near_tag[LW-1:0];

    assign pc_sat = (32'(r_pcount) > MAX_POINTS) ? MAX_POINTS : 32'(r_pcount);
    assign eff_n  = pc_sat[IW:0];
    assign is_core = (CNTW'(r_cnt) >= CNTW'(r_min_pts));

    assign coord_in[0] = i_coord_0;
    assign coord_in[1] = i_coord_1;
    assign coord_in[2] = i_coord_2;
    assign coord_in[3] = i_coord_3;

    genvar gd;
    generate
        for (gd = 0; gd < MAX_DIM; gd++) begin : g_dim
            if (gd < 4) begin : g_port
                assign load_c[gd*COORD_WIDTH +: COORD_WIDTH] = coord_in[gd];
            end else begin : g_zero
                assign load_c[gd*COORD_WIDTH +: COORD_WIDTH] = '0;
            end
            assign lane_en[gd] = (32'(r_dims) > gd);
        end
    endgenerate

    assign o_in_ready  = (r_state == dc_pkg::ST_IDLE) && (!r_ov || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign pt_we       = in_acc && (i_command == dc_pkg::CMD_LOAD);
    assign cnt_inc     = near_v && near && !r_enq;

    assign ld_plain = in_acc && (i_command != dc_pkg::CMD_READ)
                    && (i_command != dc_pkg::CMD_RUN);
    assign ld_read  = (r_state == dc_pkg::ST_READ);
    assign ld_done  = (r_state == dc_pkg::ST_DONE);

    dc_point_mem #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_DIM     (MAX_DIM),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_point_mem (
        .i_clk (i_clk),
        .i_we  (pt_we),
        .i_wa  (i_point_index),
        .i_wd  (load_c),
        .i_qwe (q_we),
        .i_qwa (r_tail[IW-1:0]),
        .i_qwd (tag_j),
        .i_ra  (pt_ra),
        .o_rd  (pt_rd),
        .o_rq  (pt_q)
    );

    dc_flag_mem #(
        .MAX_POINTS (MAX_POINTS),
        .WORD_W     (FW)
    ) u_flag_mem (
        .i_clk (i_clk),
        .i_we  (fl_we),
        .i_wa  (fl_wa),
        .i_wd  (fl_wd),
        .i_ra  (fl_ra),
        .o_rd  (fl_rd)
    );

    dc_dist #(
        .MAX_DIM     (MAX_DIM),
        .COORD_WIDTH (COORD_WIDTH),
        .TAG_W       (TW)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_v),
        .i_tag     ({r_s1_j, fl_rd}),
        .i_a       (r_cur_c),
        .i_b       (pt_rd),
        .i_lane_en (lane_en),
        .i_eps     (r_eps),
        .o_valid   (near_v),
        .o_near    (near),
        .o_tag     (near_tag),
        .o_busy    (dist_busy)
    );

    always_comb begin
        n_state = r_state;
        pt_ra   = r_j[IW-1:0];
        fl_ra   = r_j[IW-1:0];
        fl_we   = 1'b0;
        fl_wa   = r_cur;
        fl_wd   = {1'b1, r_cur_q, r_next[LW-1:0]};
        q_we    = 1'b0;
        issue   = 1'b0;
        issue_n = 1'b0;
        unique case (r_state)
            dc_pkg::ST_INIT, dc_pkg::ST_CLEAR: begin
                fl_we = 1'b1;
                fl_wa = r_k[IW-1:0];
                fl_wd = {2'b00, NOISE};
                if (r_k == LASTP) begin
                    n_state = (r_state == dc_pkg::ST_INIT) ? dc_pkg::ST_IDLE
                                                           : dc_pkg::ST_SEED;
                end
            end
            dc_pkg::ST_IDLE: begin
                fl_ra = i_point_index;
                if (in_acc && (i_command == dc_pkg::CMD_READ)) begin
                    n_state = dc_pkg::ST_READ;
                end else if (in_acc && (i_command == dc_pkg::CMD_RUN)) begin
                    n_state = dc_pkg::ST_CLEAR;
                end
            end
            dc_pkg::ST_READ: begin
                n_state = dc_pkg::ST_IDLE;
            end
            dc_pkg::ST_SEED: begin
                pt_ra = r_i[IW-1:0];
                fl_ra = r_i[IW-1:0];
                n_state = (r_i >= eff_n) ? dc_pkg::ST_NOISE : dc_pkg::ST_SEED_CHK;
            end
            dc_pkg::ST_SEED_CHK: begin
                if (fl_rf.visited) begin
                    n_state = dc_pkg::ST_SEED;
                end else begin
                    fl_we   = 1'b1;
                    fl_wa   = r_i[IW-1:0];
                    fl_wd   = {1'b1, fl_rf.queued, fl_label};
                    n_state = dc_pkg::ST_SCAN;
                end
            end
            dc_pkg::ST_SCAN: begin
                if (r_j < eff_n) begin
                    issue = 1'b1;
                end else if (!r_s1_v && !dist_busy) begin
                    n_state = r_enq ? dc_pkg::ST_POP : dc_pkg::ST_CORE;
                end
                if (near_v && near && r_enq && !tag_f.queued) begin
                    fl_we = 1'b1;
                    fl_wa = tag_j;
                    fl_wd = {tag_f.visited, 1'b1, tag_label};
                    q_we  = 1'b1;
                end
            end
            dc_pkg::ST_CORE: begin
                if (is_core) begin
                    fl_we   = r_seed;
                    n_state = dc_pkg::ST_SCAN;
                end else begin
                    n_state = r_seed ? dc_pkg::ST_SEED : dc_pkg::ST_POP;
                end
            end
            dc_pkg::ST_POP: begin
                pt_ra   = r_head[IW-1:0];
                n_state = (r_head == r_tail) ? dc_pkg::ST_SEED : dc_pkg::ST_POP_Q;
            end
            dc_pkg::ST_POP_Q: begin
                pt_ra   = pt_q;
                fl_ra   = pt_q;
                n_state = dc_pkg::ST_POP_CHK;
            end
            dc_pkg::ST_POP_CHK: begin
                fl_we = 1'b1;
                fl_wd = {1'b1, fl_rf.queued,
                         (fl_label == NOISE) ? r_next[LW-1:0] : fl_label};
                n_state = fl_rf.visited ? dc_pkg::ST_POP : dc_pkg::ST_SCAN;
            end
            dc_pkg::ST_NOISE: begin
                fl_ra = r_k[IW-1:0];
                if (r_k < eff_n) begin
                    issue_n = 1'b1;
                end else if (!r_nv) begin
                    n_state = dc_pkg::ST_DONE;
                end
            end
            dc_pkg::ST_DONE: begin
                n_state = dc_pkg::ST_IDLE;
            end
            default: begin
                n_state = dc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dc_pkg::ST_INIT;
            r_eps      <= dc_pkg::EPS_W'(1);
            r_min_pts  <= dc_pkg::MINPTS_W'(4);
            r_pcount   <= dc_pkg::PCOUNT_W'(1);
            r_dims     <= dc_pkg::DIMS_W'(2);
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
            r_next     <= '0;
            r_ncnt     <= '0;
            r_clusters <= '0;
            r_noise    <= '0;
            r_seed     <= 1'b0;
            r_enq      <= 1'b0;
            r_s1_v     <= 1'b0;
            r_nv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_v  <= issue;
            r_nv    <= issue_n;
            if (cfg_acc) begin
                case (i_cfg_index)
                    dc_pkg::CFG_EPS:         r_eps     <= i_cfg_data[dc_pkg::EPS_W-1:0];
                    dc_pkg::CFG_MIN_PTS:     r_min_pts <= i_cfg_data[dc_pkg::MINPTS_W-1:0];
                    dc_pkg::CFG_POINT_COUNT: r_pcount  <= i_cfg_data[dc_pkg::PCOUNT_W-1:0];
                    dc_pkg::CFG_DIMS:        r_dims    <= i_cfg_data[dc_pkg::DIMS_W-1:0];
                    default: ;
                endcase
            end
            if (issue) begin
                r_j <= r_j + 1'b1;
            end
            if (issue_n) begin
                r_k <= r_k + 1'b1;
            end
            if (cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (q_we) begin
                r_tail <= r_tail + 1'b1;
            end
            if (ld_plain || ld_read || ld_done) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                dc_pkg::ST_INIT, dc_pkg::ST_CLEAR: begin
                    r_k <= (r_k == LASTP) ? '0 : r_k + 1'b1;
                end
                dc_pkg::ST_IDLE: begin
                    if (in_acc && (i_command == dc_pkg::CMD_RUN)) begin
                        r_k    <= '0;
                        r_i    <= '0;
                        r_head <= '0;
                        r_tail <= '0;
                        r_next <= '0;
                        r_ncnt <= '0;
                    end
                end
                dc_pkg::ST_SEED: begin
                    if (r_i >= eff_n) begin
                        r_k <= '0;
                    end
                end
                dc_pkg::ST_SEED_CHK: begin
                    if (fl_rf.visited) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j    <= '0;
                        r_cnt  <= '0;
                        r_enq  <= 1'b0;
                        r_seed <= 1'b1;
                    end
                end
                dc_pkg::ST_CORE: begin
                    if (is_core) begin
                        r_j   <= '0;
                        r_enq <= 1'b1;
                    end else if (r_seed) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                dc_pkg::ST_POP: begin
                    if (r_head == r_tail) begin
                        r_next <= r_next + 1'b1;
                        r_i    <= r_i + 1'b1;
                    end else begin
                        r_head <= r_head + 1'b1;
                    end
                end
                dc_pkg::ST_POP_CHK: begin
                    if (!fl_rf.visited) begin
                        r_j    <= '0;
                        r_cnt  <= '0;
                        r_enq  <= 1'b0;
                        r_seed <= 1'b0;
                    end
                end
                dc_pkg::ST_NOISE: begin
                    if (r_nv && (fl_label == NOISE)) begin
                        r_ncnt <= r_ncnt + 1'b1;
                    end
                end
                dc_pkg::ST_DONE: begin
                    r_clusters <= r_next;
                    r_noise    <= r_ncnt;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_j <= r_j[IW-1:0];
        if (r_state == dc_pkg::ST_SEED_CHK) begin
            r_cur_c <= pt_rd;
            r_cur   <= r_i[IW-1:0];
            r_cur_q <= fl_rf.queued;
        end
        if (r_state == dc_pkg::ST_POP_Q) begin
            r_cur <= pt_q;
        end
        if (r_state == dc_pkg::ST_POP_CHK) begin
            r_cur_c <= pt_rd;
            r_cur_q <= fl_rf.queued;
        end
        if (in_acc) begin
            r_rd_bad <= !({1'b0, i_point_index} < eff_n);
        end
        if (ld_plain) begin
            r_o_label    <= '0;
            r_o_status   <= 1'b0;
            r_o_clusters <= r_clusters;
            r_o_noise    <= r_noise;
        end else if (ld_read) begin
            r_o_label    <= r_rd_bad ? '0 : fl_label;
            r_o_status   <= r_rd_bad;
            r_o_clusters <= r_clusters;
            r_o_noise    <= r_noise;
        end else if (ld_done) begin
            r_o_label    <= '0;
            r_o_status   <= 1'b0;
            r_o_clusters <= r_next;
            r_o_noise    <= r_ncnt;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_label         = r_o_label;
    assign o_cluster_total = r_o_clusters;
    assign o_noise_total   = r_o_noise;
    assign o_status        = r_o_status;

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= MAXP)
        else $error("queue overfilled");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dc_pkg::ST_IDLE) |-> (!r_s1_v && !dist_busy))
        else $error("distance pipeline active while idle");

    a_cluster_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dc_pkg::ST_SEED) |-> (r_next <= r_i))
        else $error("more clusters than seeds");

endmodule

`default_nettype wire
